// File: rtl/mdpm_pkg.sv
// ----------------------------------------------------------------------------
// mdpm_pkg
// Shared widths, constants, register map, command types and the
// divide-by-constant tables of the motor drive protection monitor.
// ----------------------------------------------------------------------------
package mdpm_pkg;

   // moving average depth and the write slot that walks it
   localparam int AVG_DEPTH = 10;
   localparam int SLOT_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;

   // field widths
   localparam int ADC_W    = 10;
   localparam int PWM_W    = 14;
   localparam int MA_W     = 11;
   localparam int AC_W     = 9;
   localparam int SUM_W    = 14;
   localparam int LIMIT_W  = 12;
   localparam int VLIM_W   = 9;
   localparam int TRIP_W   = 8;
   localparam int CSR_DW   = 32;
   localparam int CSR_AW   = 5;

   // intermediate widths of the scaling chain
   localparam int AVG_W    = 11;
   localparam int MV_W     = 13;
   localparam int CAP_W    = 10;

   // scaling constants
   localparam int VREF_MV        = 5000;
   localparam int ADC_FULL       = 1023;
   localparam int SHUNT_SCALE    = 10;
   localparam int SHUNT_DIV      = 28;
   localparam int DIVIDER_FACTOR = 91;
   localparam int MV_PER_V       = 1000;
   localparam int RMS_SCALE      = 1000;
   localparam int RMS_FACTOR     = 1414;
   localparam int PWM_TOP        = 20000;
   localparam int DUTY_SCALE     = PWM_TOP / 2;
   localparam int RUN_MAX        = 255;

   // register reset values
   localparam int CURRENT_LIMIT_RST = 2000;
   localparam int OV_LIMIT_RST      = 270;
   localparam int UV_LIMIT_RST      = 120;
   localparam int TRIP_COUNT_RST    = 10;
   localparam int DEADBAND_RST      = 25;

   // shared scale-and-divide pipeline: q = (a * k) / d, exact for a * k < 2**X_W
   localparam int OPND_W = 14;
   localparam int K_W    = 14;
   localparam int X_W    = 24;
   localparam int M_W    = 25;
   localparam int P_W    = X_W + M_W;
   localparam int Q_W    = 14;
   localparam int SH_W   = 6;

   localparam int S_AVG  = X_W + $clog2(AVG_DEPTH);
   localparam int S_ADC  = X_W + $clog2(ADC_FULL);
   localparam int S_SHNT = X_W + $clog2(SHUNT_DIV);
   localparam int S_MV   = X_W + $clog2(MV_PER_V);
   localparam int S_RMS  = X_W + $clog2(RMS_FACTOR);

   localparam logic [M_W-1:0] M_AVG  =
      M_W'(((64'd1 << S_AVG) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));
   localparam logic [M_W-1:0] M_ADC  =
      M_W'(((64'd1 << S_ADC) + 64'(ADC_FULL) - 64'd1) / 64'(ADC_FULL));
   localparam logic [M_W-1:0] M_SHNT =
      M_W'(((64'd1 << S_SHNT) + 64'(SHUNT_DIV) - 64'd1) / 64'(SHUNT_DIV));
   localparam logic [M_W-1:0] M_MV   =
      M_W'(((64'd1 << S_MV) + 64'(MV_PER_V) - 64'd1) / 64'(MV_PER_V));
   localparam logic [M_W-1:0] M_RMS  =
      M_W'(((64'd1 << S_RMS) + 64'(RMS_FACTOR) - 64'd1) / 64'(RMS_FACTOR));

   // register map
   typedef enum logic [2:0] {
      CSR_CURRENT_LIMIT = 3'd0,
      CSR_OV_LIMIT      = 3'd1,
      CSR_UV_LIMIT      = 3'd2,
      CSR_CURRENT_TRIP  = 3'd3,
      CSR_VOLTAGE_TRIP  = 3'd4,
      CSR_POT_DEADBAND  = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] current_limit_ma;
      logic [VLIM_W-1:0]  overvoltage_limit;
      logic [VLIM_W-1:0]  undervoltage_limit;
      logic [TRIP_W-1:0]  current_trip_count;
      logic [TRIP_W-1:0]  voltage_trip_count;
      logic [ADC_W-1:0]   pot_deadband;
   } cfg_type;

   // scaling steps: c = current chain, v = voltage chain, d = duty
   typedef enum logic [2:0] {
      STEP_C0 = 3'd0,   // current sum / depth
      STEP_V0 = 3'd1,   // voltage sum / depth
      STEP_D0 = 3'd2,   // pot * 10000 / 1023
      STEP_C1 = 3'd3,   // avg * 5000 / 1023 -> mV
      STEP_V1 = 3'd4,   // avg * 5000 / 1023 -> dc mV
      STEP_C2 = 3'd5,   // mV * 10 / 28 -> mA
      STEP_V2 = 3'd6,   // dc * 91 / 1000
      STEP_V3 = 3'd7    // cap * 1000 / 1414 -> ac volts
   } step_type;

   typedef struct packed {
      logic     load;
      logic     push;
      logic     issue;
      step_type step;
      logic     finish;
   } dp_cmd_type;

   function automatic logic [K_W-1:0] step_scale(input step_type step);
      logic [K_W-1:0] k;
      unique case (step) inside
         STEP_C0, STEP_V0: k = K_W'(1);
         STEP_D0:          k = K_W'(DUTY_SCALE);
         STEP_C1, STEP_V1: k = K_W'(VREF_MV);
         STEP_C2:          k = K_W'(SHUNT_SCALE);
         STEP_V2:          k = K_W'(DIVIDER_FACTOR);
         STEP_V3:          k = K_W'(RMS_SCALE);
         default:          k = K_W'(1);
      endcase
      return k;
   endfunction

   function automatic logic [M_W-1:0] step_magic(input step_type step);
      logic [M_W-1:0] m;
      unique case (step) inside
         STEP_C0, STEP_V0:          m = M_AVG;
         STEP_D0, STEP_C1, STEP_V1: m = M_ADC;
         STEP_C2:                   m = M_SHNT;
         STEP_V2:                   m = M_MV;
         STEP_V3:                   m = M_RMS;
         default:                   m = M_AVG;
      endcase
      return m;
   endfunction

   function automatic logic [SH_W-1:0] step_shift(input step_type step);
      logic [SH_W-1:0] s;
      unique case (step) inside
         STEP_C0, STEP_V0:          s = SH_W'(S_AVG);
         STEP_D0, STEP_C1, STEP_V1: s = SH_W'(S_ADC);
         STEP_C2:                   s = SH_W'(S_SHNT);
         STEP_V2:                   s = SH_W'(S_MV);
         STEP_V3:                   s = SH_W'(S_RMS);
         default:                   s = SH_W'(S_AVG);
      endcase
      return s;
   endfunction

endpackage

// File: rtl/mdpm_csr.sv
// ----------------------------------------------------------------------------
// mdpm_csr
// Configuration registers behind a simple apb-style port, no wait states.
// ----------------------------------------------------------------------------
module mdpm_csr import mdpm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type     cfg_ff;
   logic        wr_en;
   csr_idx_type idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = csr_idx_type'(paddr[CSR_AW-1:2]);
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.current_limit_ma   <= LIMIT_W'(CURRENT_LIMIT_RST);
         cfg_ff.overvoltage_limit  <= VLIM_W'(OV_LIMIT_RST);
         cfg_ff.undervoltage_limit <= VLIM_W'(UV_LIMIT_RST);
         cfg_ff.current_trip_count <= TRIP_W'(TRIP_COUNT_RST);
         cfg_ff.voltage_trip_count <= TRIP_W'(TRIP_COUNT_RST);
         cfg_ff.pot_deadband       <= ADC_W'(DEADBAND_RST);
      end else if (wr_en) begin
         unique case (idx)
            CSR_CURRENT_LIMIT: cfg_ff.current_limit_ma   <= pwdata[LIMIT_W-1:0];
            CSR_OV_LIMIT:      cfg_ff.overvoltage_limit  <= pwdata[VLIM_W-1:0];
            CSR_UV_LIMIT:      cfg_ff.undervoltage_limit <= pwdata[VLIM_W-1:0];
            CSR_CURRENT_TRIP:  cfg_ff.current_trip_count <= pwdata[TRIP_W-1:0];
            CSR_VOLTAGE_TRIP:  cfg_ff.voltage_trip_count <= pwdata[TRIP_W-1:0];
            CSR_POT_DEADBAND:  cfg_ff.pot_deadband       <= pwdata[ADC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         CSR_CURRENT_LIMIT: prdata = CSR_DW'(cfg_ff.current_limit_ma);
         CSR_OV_LIMIT:      prdata = CSR_DW'(cfg_ff.overvoltage_limit);
         CSR_UV_LIMIT:      prdata = CSR_DW'(cfg_ff.undervoltage_limit);
         CSR_CURRENT_TRIP:  prdata = CSR_DW'(cfg_ff.current_trip_count);
         CSR_VOLTAGE_TRIP:  prdata = CSR_DW'(cfg_ff.voltage_trip_count);
         CSR_POT_DEADBAND:  prdata = CSR_DW'(cfg_ff.pot_deadband);
         default:           prdata = '0;
      endcase
   end

endmodule

// File: rtl/mdpm_ctrl.sv
// ----------------------------------------------------------------------------
// mdpm_ctrl
// Sequencer: takes a word, runs the window update and then issues the
// scaling steps to the shared divide pipeline in dependency order.
// ----------------------------------------------------------------------------
module mdpm_ctrl import mdpm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd
);

   typedef enum logic [15:0] {
      ST_IDLE   = 16'h0001,
      ST_PUSH   = 16'h0002,
      ST_C0     = 16'h0004,
      ST_V0     = 16'h0008,
      ST_D0     = 16'h0010,
      ST_C1     = 16'h0020,
      ST_V1     = 16'h0040,
      ST_GAP1   = 16'h0080,
      ST_C2     = 16'h0100,
      ST_V2     = 16'h0200,
      ST_GAP2   = 16'h0400,
      ST_GAP3   = 16'h0800,
      ST_V3     = 16'h1000,
      ST_DRAIN1 = 16'h2000,
      ST_DRAIN2 = 16'h4000,
      ST_DONE   = 16'h8000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // a step's result is written back after the x and p pipeline registers; dependents wait for it
   always_comb begin
      cmd        = '0;
      cmd.step   = STEP_C0;
      cmd.load   = req_valid && (state_ff == ST_IDLE);
      state_in   = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PUSH;
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = ST_C0;
         end
         ST_C0: begin
            cmd.issue = 1'b1;
            cmd.step  = STEP_C0;
            state_in  = ST_V0;
         end
         ST_V0: begin
            cmd.issue = 1'b1;
            cmd.step  = STEP_V0;
            state_in  = ST_D0;
         end
         ST_D0: begin
            cmd.issue = 1'b1;
            cmd.step  = STEP_D0;
            state_in  = ST_C1;
         end
         ST_C1: begin
            cmd.issue = 1'b1;
            cmd.step  = STEP_C1;
            state_in  = ST_V1;
         end
         ST_V1: begin
            cmd.issue = 1'b1;
            cmd.step  = STEP_V1;
            state_in  = ST_GAP1;
         end
         ST_GAP1: state_in = ST_C2;
         ST_C2: begin
            cmd.issue = 1'b1;
            cmd.step  = STEP_C2;
            state_in  = ST_V2;
         end
         ST_V2: begin
            cmd.issue = 1'b1;
            cmd.step  = STEP_V2;
            state_in  = ST_GAP2;
         end
         ST_GAP2: state_in = ST_GAP3;
         ST_GAP3: state_in = ST_V3;
         ST_V3: begin
            cmd.issue = 1'b1;
            cmd.step  = STEP_V3;
            state_in  = ST_DRAIN1;
         end
         ST_DRAIN1: state_in = ST_DRAIN2;
         ST_DRAIN2: state_in = ST_DONE;
         ST_DONE: begin
            // move into the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.finish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/mdpm_datapath.sv
// ----------------------------------------------------------------------------
// mdpm_datapath
// Averaging windows, fault qualifiers, hall steering, a shared two-stage
// scale-and-divide pipeline and the result register.
// ----------------------------------------------------------------------------
module mdpm_datapath import mdpm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  dp_cmd_type       cmd,
   input  cfg_type          cfg,
   input  logic [ADC_W-1:0] req_pot_sample,
   input  logic [ADC_W-1:0] req_current_sample,
   input  logic [ADC_W-1:0] req_voltage_sample,
   input  logic             req_hall_a_low,
   input  logic             req_hall_b_low,
   output logic [PWM_W-1:0] rsp_pwm_one_compare,
   output logic [PWM_W-1:0] rsp_pwm_two_compare,
   output logic [PWM_W-1:0] rsp_duty_value,
   output logic             rsp_overcurrent_fault,
   output logic             rsp_voltage_fault,
   output logic [MA_W-1:0]  rsp_current_milliamps,
   output logic [AC_W-1:0]  rsp_ac_volts
);

   // captured word
   logic [ADC_W-1:0]  pot_ff, pot_in;
   logic [ADC_W-1:0]  cur_ff, vol_ff;
   logic              hall_a_ff, hall_b_ff;

   // averaging windows
   logic [ADC_W-1:0]  cwin_ff [AVG_DEPTH];
   logic [ADC_W-1:0]  vwin_ff [AVG_DEPTH];
   logic [SUM_W-1:0]  csum_ff, csum_in, vsum_ff, vsum_in;
   logic [SLOT_W-1:0] cslot_ff, cslot_in, vslot_ff, vslot_in;

   // qualifiers and steering
   logic [TRIP_W-1:0] oc_run_ff, oc_run_in, bv_run_ff, bv_run_in;
   logic              oc_ff, oc_in, vb_ff, vb_in;
   logic [PWM_W-1:0]  pwm_one_ff, pwm_one_in, pwm_two_ff, pwm_two_in;
   logic [PWM_W-1:0]  duty_ff;
   logic [MA_W-1:0]   ma_ff;
   logic [AC_W-1:0]   ac_ff;
   logic              v_out;

   // result register
   logic [PWM_W-1:0]  rsp_pwm_one_ff, rsp_pwm_two_ff, rsp_duty_ff;
   logic              rsp_oc_ff, rsp_vb_ff;
   logic [MA_W-1:0]   rsp_ma_ff;
   logic [AC_W-1:0]   rsp_ac_ff;

   // scaling chain intermediates
   logic [AVG_W-1:0]  avg_c_ff, avg_v_ff;
   logic [MV_W-1:0]   mv_ff, dc_ff;
   logic [CAP_W-1:0]  cap_ff;

   // divide pipeline
   logic [OPND_W-1:0]       opnd;
   logic [OPND_W+K_W-1:0]   scaled;
   logic [X_W-1:0]          x_ff;
   logic [P_W-1:0]          p_ff;
   logic [Q_W-1:0]          q;
   logic                    s1_valid_ff, s2_valid_ff;
   step_type                s1_step_ff, s2_step_ff;

   assign rsp_pwm_one_compare   = rsp_pwm_one_ff;
   assign rsp_pwm_two_compare   = rsp_pwm_two_ff;
   assign rsp_duty_value        = rsp_duty_ff;
   assign rsp_overcurrent_fault = rsp_oc_ff;
   assign rsp_voltage_fault     = rsp_vb_ff;
   assign rsp_current_milliamps = rsp_ma_ff;
   assign rsp_ac_volts          = rsp_ac_ff;

   // ---------------------------------------------------------------- push
   always_comb begin
      pot_in = pot_ff;
      if (pot_ff <= cfg.pot_deadband) pot_in = '0;

      csum_in  = csum_ff - SUM_W'(cwin_ff[cslot_ff]) + SUM_W'(cur_ff);
      vsum_in  = vsum_ff - SUM_W'(vwin_ff[vslot_ff]) + SUM_W'(vol_ff);
      cslot_in = (cslot_ff == SLOT_W'(AVG_DEPTH - 1)) ? '0 : cslot_ff + 1'b1;
      vslot_in = (vslot_ff == SLOT_W'(AVG_DEPTH - 1)) ? '0 : vslot_ff + 1'b1;

      // hall a wins when both lines are low; neither low holds both
      pwm_one_in = pwm_one_ff;
      pwm_two_in = pwm_two_ff;
      if (hall_a_ff) begin
         pwm_one_in = duty_ff;
         pwm_two_in = '0;
      end else if (hall_b_ff) begin
         pwm_two_in = duty_ff;
         pwm_one_in = '0;
      end

      // deadband clears the latch before this check
      oc_in     = oc_ff && !(pot_ff <= cfg.pot_deadband);
      oc_run_in = oc_run_ff;
      if (LIMIT_W'(ma_ff) > cfg.current_limit_ma) begin
         if (oc_run_ff != TRIP_W'(RUN_MAX)) oc_run_in = oc_run_ff + 1'b1;
         if (oc_run_in >= cfg.current_trip_count) oc_in = 1'b1;
      end else if (LIMIT_W'(ma_ff) < cfg.current_limit_ma) begin
         oc_run_in = '0;
      end

      v_out = (ac_ff > cfg.overvoltage_limit) || (ac_ff < cfg.undervoltage_limit);
      vb_in = vb_ff;
      bv_run_in = bv_run_ff;
      if (v_out) begin
         if (bv_run_ff != TRIP_W'(RUN_MAX)) bv_run_in = bv_run_ff + 1'b1;
         if (bv_run_in >= cfg.voltage_trip_count) vb_in = 1'b1;
      end else begin
         bv_run_in = '0;
         vb_in     = 1'b0;
      end
   end

   // ------------------------------------------------------- divide pipeline
   always_comb begin
      case (cmd.step)
         STEP_C0: opnd = OPND_W'(csum_ff);
         STEP_V0: opnd = OPND_W'(vsum_ff);
         STEP_D0: opnd = OPND_W'(pot_ff);
         STEP_C1: opnd = OPND_W'(avg_c_ff);
         STEP_V1: opnd = OPND_W'(avg_v_ff);
         STEP_C2: opnd = OPND_W'(mv_ff);
         STEP_V2: opnd = OPND_W'(dc_ff);
         STEP_V3: opnd = OPND_W'(cap_ff);
         default: opnd = '0;
      endcase
   end

   assign scaled = (OPND_W + K_W)'(opnd) * (OPND_W + K_W)'(step_scale(cmd.step));
   // reciprocal multiply, the shift is a wiring choice per step
   assign q      = Q_W'(p_ff >> step_shift(s2_step_ff));

   always_ff @(posedge clock) begin
      s1_step_ff <= cmd.step;
      s2_step_ff <= s1_step_ff;
      x_ff       <= X_W'(scaled);
      p_ff       <= P_W'(x_ff) * P_W'(step_magic(s1_step_ff));
   end

   // ---------------------------------------------------- payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pot_ff    <= req_pot_sample;
         cur_ff    <= req_current_sample;
         vol_ff    <= req_voltage_sample;
         hall_a_ff <= req_hall_a_low;
         hall_b_ff <= req_hall_b_low;
      end else if (cmd.push) begin
         pot_ff <= pot_in;
      end
      if (s2_valid_ff) begin
         case (s2_step_ff)
            STEP_C0: avg_c_ff <= q[AVG_W-1:0];
            STEP_V0: avg_v_ff <= q[AVG_W-1:0];
            STEP_C1: mv_ff    <= q[MV_W-1:0];
            STEP_V1: dc_ff    <= q[MV_W-1:0];
            STEP_V2: cap_ff   <= q[CAP_W-1:0];
            default: begin
            end
         endcase
      end
      if (cmd.finish) begin
         rsp_pwm_one_ff <= pwm_one_ff;
         rsp_pwm_two_ff <= pwm_two_ff;
         rsp_duty_ff    <= duty_ff;
         rsp_oc_ff      <= oc_ff;
         rsp_vb_ff      <= vb_ff;
         rsp_ma_ff      <= ma_ff;
         rsp_ac_ff      <= ac_ff;
      end
   end

   // ------------------------------------------------------------ state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AVG_DEPTH; i++) begin
            cwin_ff[i] <= '0;
            vwin_ff[i] <= '0;
         end
         csum_ff     <= '0;
         vsum_ff     <= '0;
         cslot_ff    <= '0;
         vslot_ff    <= '0;
         oc_run_ff   <= '0;
         bv_run_ff   <= '0;
         oc_ff       <= 1'b0;
         vb_ff       <= 1'b0;
         pwm_one_ff  <= '0;
         pwm_two_ff  <= '0;
         duty_ff     <= '0;
         ma_ff       <= '0;
         ac_ff       <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff;
         if (cmd.push) begin
            cwin_ff[cslot_ff] <= cur_ff;
            vwin_ff[vslot_ff] <= vol_ff;
            csum_ff    <= csum_in;
            vsum_ff    <= vsum_in;
            cslot_ff   <= cslot_in;
            vslot_ff   <= vslot_in;
            oc_run_ff  <= oc_run_in;
            bv_run_ff  <= bv_run_in;
            oc_ff      <= oc_in;
            vb_ff      <= vb_in;
            pwm_one_ff <= pwm_one_in;
            pwm_two_ff <= pwm_two_in;
         end
         if (s2_valid_ff) begin
            case (s2_step_ff)
               STEP_D0: duty_ff <= (oc_ff || vb_ff) ? '0 : q[PWM_W-1:0];
               STEP_C2: ma_ff   <= q[MA_W-1:0];
               STEP_V3: ac_ff   <= q[AC_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

endmodule

// File: rtl/motor_drive_protection_monitor.sv
// ----------------------------------------------------------------------------
// motor_drive_protection_monitor
// Hall steered pwm duty with moving-average overcurrent and voltage trips.
// ----------------------------------------------------------------------------
// Each word is one adc scan plus two hall lines and gives one result word.
// The block takes a word only while idle, once the result of the last word
// has moved into the output register; the next word is taken while that
// result waits in the output register. The pace is set by the single
// shared scale-and-divide pipeline (x and p registers from issue to write
// back) and the four dependent steps that turn the voltage sum into ac volts.
// The averaging windows are flip-flops cleared directly by reset.
module motor_drive_protection_monitor import mdpm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [ADC_W-1:0]  req_pot_sample,
   input  logic [ADC_W-1:0]  req_current_sample,
   input  logic [ADC_W-1:0]  req_voltage_sample,
   input  logic              req_hall_a_low,
   input  logic              req_hall_b_low,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [PWM_W-1:0]  rsp_pwm_one_compare,
   output logic [PWM_W-1:0]  rsp_pwm_two_compare,
   output logic [PWM_W-1:0]  rsp_duty_value,
   output logic              rsp_overcurrent_fault,
   output logic              rsp_voltage_fault,
   output logic [MA_W-1:0]   rsp_current_milliamps,
   output logic [AC_W-1:0]   rsp_ac_volts,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   cfg_type    cfg;
   dp_cmd_type cmd;

   mdpm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mdpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   mdpm_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .cfg                   (cfg),
      .req_pot_sample        (req_pot_sample),
      .req_current_sample    (req_current_sample),
      .req_voltage_sample    (req_voltage_sample),
      .req_hall_a_low        (req_hall_a_low),
      .req_hall_b_low        (req_hall_b_low),
      .rsp_pwm_one_compare   (rsp_pwm_one_compare),
      .rsp_pwm_two_compare   (rsp_pwm_two_compare),
      .rsp_duty_value        (rsp_duty_value),
      .rsp_overcurrent_fault (rsp_overcurrent_fault),
      .rsp_voltage_fault     (rsp_voltage_fault),
      .rsp_current_milliamps (rsp_current_milliamps),
      .rsp_ac_volts          (rsp_ac_volts)
   );

   // any active fault forces zero duty
   a_fault_zero_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_overcurrent_fault || rsp_voltage_fault) |->
         rsp_duty_value == '0)
      else $error("duty nonzero with a fault active");

   // steering never drives both channels at once
   a_one_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pwm_one_compare == '0) || (rsp_pwm_two_compare == '0))
      else $error("both pwm channels driven");

   // duty stays within half of the pwm period
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duty_value <= PWM_W'(DUTY_SCALE))
      else $error("duty above full scale");

   // a taken word is never offered before the scaling chain has run
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result offered right after a word was taken");

endmodule
